// ===== hw/rtl/neighbor_rule_pixel_filter_macros.svh =====
// ---------------------------------------------------------------------------
// neighbor rule pixel filter assertion macros
// shared assertion shorthands for the filter modules
// ---------------------------------------------------------------------------
`ifndef NEIGHBOR_RULE_PIXEL_FILTER_MACROS_SVH
`define NEIGHBOR_RULE_PIXEL_FILTER_MACROS_SVH

// property must hold at every rising edge outside reset
`define NRPF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define NRPF_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/nrpf_pkg.sv =====
// ---------------------------------------------------------------------------
// nrpf_pkg
// types, constants and register codes shared by the pixel filter modules
// ---------------------------------------------------------------------------
package nrpf_pkg;

  // field and register widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  // geometry limits
  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned MIN_DIM       = 3;

  // window layout, raster order inside the 3x3 window
  localparam int unsigned WIN_N      = 9;
  localparam int unsigned WIN_NORTH  = 1;
  localparam int unsigned WIN_WEST   = 3;
  localparam int unsigned WIN_CENTRE = 4;
  localparam int unsigned WIN_EAST   = 5;
  localparam int unsigned WIN_SOUTH  = 7;

  // neighbour count at or below which the sparse code is used
  localparam int unsigned SPARSE_LIMIT = 3;

  // result queue depth
  localparam int unsigned OUTQ_DEPTH = 3;

  // register reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);
  localparam logic [PIX_W-1:0] SPARSE_CODE_RST  = '0;
  localparam logic [PIX_W-1:0] DENSE_CODE_RST   = '0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_SPARSE_CODE  = 2'd2,
    CFG_DENSE_CODE   = 2'd3
  } cfg_reg_e;

  // request kinds
  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_type_e;

  // one request handed from position control to the datapath
  typedef struct packed {
    logic             valid;
    logic             flush;
    logic             emit;
    logic             border;
    logic             interior;
    logic             last;
    logic             sel_mid;
    logic [PIX_W-1:0] pix;
  } issue_t;

  // one result
  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pixel;
  } out_item_t;

endpackage

// ===== hw/rtl/nrpf_ram.sv =====
// ---------------------------------------------------------------------------
// nrpf_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module nrpf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and read; a read of the entry written at the same edge sees old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/nrpf_ctrl.sv =====
// ---------------------------------------------------------------------------
// nrpf_ctrl
// configuration registers, input and output raster positions, request issue
// ---------------------------------------------------------------------------
`include "neighbor_rule_pixel_filter_macros.svh"

module nrpf_ctrl #(
  parameter int unsigned MaxWidth = nrpf_pkg::MAX_WIDTH_DEF,
  localparam int unsigned ColW = $clog2(MaxWidth)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nrpf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nrpf_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             accept_i,
  input  nrpf_pkg::req_type_e              req_type_i,
  input  logic [nrpf_pkg::PIX_W-1:0]       pixel_i,
  output nrpf_pkg::issue_t                 issue_o,
  output logic [ColW-1:0]                  addr_o,
  output logic [nrpf_pkg::PIX_W-1:0]       sparse_code_o,
  output logic [nrpf_pkg::PIX_W-1:0]       dense_code_o
);

  import nrpf_pkg::*;

  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [PIX_W-1:0] sparse_code_q, dense_code_q;

  logic [ColW-1:0]  in_column_q, in_column_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [ColW-1:0]  out_column_q, out_column_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;

  logic [ColW:0]    width_eff, w_m1;
  logic [ROW_W-1:0] height_eff, h_m1;
  logic             col_wrap;
  logic [ColW-1:0]  col0;
  logic [ROW_W-1:0] row0;
  logic             flush;
  logic             border, center, interior;
  logic             out_end;
  logic [ColW:0]    out_col_inc, pix_col_inc;
  logic [ColW-1:0]  out_col_nx, flush_addr;
  logic [ROW_W-1:0] out_row_nx;
  issue_t           issue;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      sparse_code_q  <= SPARSE_CODE_RST;
      dense_code_q   <= DENSE_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_SPARSE_CODE:  sparse_code_q  <= cfg_data_i[PIX_W-1:0];
        CFG_DENSE_CODE:   dense_code_q   <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign sparse_code_o = sparse_code_q;
  assign dense_code_o  = dense_code_q;

  // clamped geometry
  always_comb begin
    if (frame_width_q < CFG_W'(MIN_DIM)) begin
      width_eff = (ColW+1)'(MIN_DIM);
    end else if (32'(frame_width_q) > MaxWidth) begin
      width_eff = (ColW+1)'(MaxWidth);
    end else begin
      width_eff = (ColW+1)'(frame_width_q);
    end
    if (frame_height_q < CFG_W'(MIN_DIM)) begin
      height_eff = ROW_W'(MIN_DIM);
    end else begin
      height_eff = frame_height_q;
    end
  end

  assign w_m1 = width_eff - (ColW+1)'(1);
  assign h_m1 = height_eff - ROW_W'(1);

  // input position after the end-of-row wrap
  assign col_wrap = {1'b0, in_column_q} >= width_eff;
  assign col0     = col_wrap ? '0 : in_column_q;
  assign row0     = col_wrap ? in_row_q + ROW_W'(1) : in_row_q;
  assign flush    = row0 >= height_eff;

  // pixel decisions: border pixel of the row before, window centre, interior
  assign border      = (col0 == '0) && (row0 >= ROW_W'(2));
  assign center      = (col0 != '0) && (row0 != '0);
  assign interior    = (row0 >= ROW_W'(2)) && (col0 >= ColW'(2));
  assign pix_col_inc = {1'b0, col0} + (ColW+1)'(1);

  // output position step
  assign out_end     = (out_row_q >= h_m1) && ({1'b0, out_column_q} >= w_m1);
  assign out_col_inc = {1'b0, out_column_q} + (ColW+1)'(1);

  always_comb begin
    if (out_end) begin
      out_col_nx = '0;
      out_row_nx = '0;
    end else if (out_col_inc >= width_eff) begin
      out_col_nx = '0;
      out_row_nx = out_row_q + ROW_W'(1);
    end else begin
      out_col_nx = out_col_inc[ColW-1:0];
      out_row_nx = out_row_q;
    end
  end

  // flush reads the stored row of the pending output, column clamped
  assign flush_addr = ({1'b0, out_column_q} < width_eff) ? out_column_q : w_m1[ColW-1:0];

  // request issue and position update
  always_comb begin
    in_column_d    = in_column_q;
    in_row_d       = in_row_q;
    out_column_d   = out_column_q;
    out_row_d      = out_row_q;
    addr_o         = col0;
    issue          = '0;
    issue.flush    = flush;
    issue.border   = border;
    issue.interior = interior;
    issue.last     = out_end;
    issue.sel_mid  = out_row_q >= h_m1;
    issue.pix      = pixel_i;
    if (flush) begin
      addr_o      = flush_addr;
      issue.valid = accept_i;
      issue.emit  = 1'b1;
      if (accept_i) begin
        out_column_d = out_col_nx;
        out_row_d    = out_row_nx;
        if (out_end) begin
          in_column_d = '0;
          in_row_d    = '0;
        end else begin
          in_column_d = col0;
          in_row_d    = row0;
        end
      end
    end else if (req_type_i == REQ_DRAIN) begin
      if (accept_i) begin
        in_column_d = col0;
        in_row_d    = row0;
      end
    end else begin
      issue.valid = accept_i;
      issue.emit  = border || center;
      if (accept_i) begin
        if (pix_col_inc >= width_eff) begin
          in_column_d = '0;
          in_row_d    = row0 + ROW_W'(1);
        end else begin
          in_column_d = pix_col_inc[ColW-1:0];
          in_row_d    = row0;
        end
        if (border || center) begin
          out_column_d = out_col_nx;
          out_row_d    = out_row_nx;
        end
      end
    end
  end

  assign issue_o = issue;

  // position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_column_q  <= '0;
      in_row_q     <= '0;
      out_column_q <= '0;
      out_row_q    <= '0;
    end else begin
      in_column_q  <= in_column_d;
      in_row_q     <= in_row_d;
      out_column_q <= out_column_d;
      out_row_q    <= out_row_d;
    end
  end

  // the final pixel of a frame returns the output position to the origin
  `NRPF_ASSERT(a_last_resets_out, clk_i, rst_ni, issue_o.valid && issue_o.emit && issue_o.last |=> out_row_q == '0 && out_column_q == '0, "output position not at origin after frame end")

  // a finished flush also returns the input position to the origin
  `NRPF_ASSERT(a_flush_end_resets_in, clk_i, rst_ni, issue_o.valid && issue_o.flush && issue_o.last |=> in_row_q == '0 && in_column_q == '0, "input position not at origin after flush")

endmodule

// ===== hw/rtl/nrpf_dpath.sv =====
// ---------------------------------------------------------------------------
// nrpf_dpath
// two line stores, upper store forwarding, 3x3 window and neighbour rule
// ---------------------------------------------------------------------------
`include "neighbor_rule_pixel_filter_macros.svh"

module nrpf_dpath #(
  parameter int unsigned MaxWidth = nrpf_pkg::MAX_WIDTH_DEF,
  localparam int unsigned ColW = $clog2(MaxWidth)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nrpf_pkg::issue_t           issue_i,
  input  logic [ColW-1:0]            addr_i,
  input  logic [nrpf_pkg::PIX_W-1:0] sparse_code_i,
  input  logic [nrpf_pkg::PIX_W-1:0] dense_code_i,
  output logic                       push_o,
  output nrpf_pkg::out_item_t        item_o
);

  import nrpf_pkg::*;

  issue_t           s1_q;
  logic [ColW-1:0]  s1_addr_q;
  logic [PIX_W-1:0] up_rd, mid_rd, up_eff;
  logic             upper_we;
  logic             fwd_hit_q, fwd_hit_d;
  logic [PIX_W-1:0] fwd_data_q;
  logic [PIX_W-1:0] win_q [WIN_N];
  logic [PIX_W-1:0] win_d [WIN_N];
  logic [3:0]       nb_cnt;
  logic             keep;
  logic [PIX_W-1:0] value;

  // upper store: written back in the cycle after the read with the old middle value
  assign upper_we = s1_q.valid && !s1_q.flush;

  nrpf_ram #(
    .Width (PIX_W),
    .Depth (MaxWidth)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (upper_we),
    .waddr_i (s1_addr_q),
    .wdata_i (mid_rd),
    .re_i    (issue_i.valid),
    .raddr_i (addr_i),
    .rdata_o (up_rd)
  );

  // middle store: read old value and write the new pixel at the same edge
  nrpf_ram #(
    .Width (PIX_W),
    .Depth (MaxWidth)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (issue_i.valid && !issue_i.flush),
    .waddr_i (addr_i),
    .wdata_i (issue_i.pix),
    .re_i    (issue_i.valid),
    .raddr_i (addr_i),
    .rdata_o (mid_rd)
  );

  // forward the upper write that coincides with a read of the same entry
  assign fwd_hit_d = upper_we && issue_i.valid && (addr_i == s1_addr_q);
  assign up_eff    = fwd_hit_q ? fwd_data_q : up_rd;

  // stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      fwd_hit_q <= 1'b0;
    end else begin
      s1_q      <= issue_i;
      fwd_hit_q <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= addr_i;
    fwd_data_q <= mid_rd;
  end

  // window shift on every pixel request
  always_comb begin
    win_d = win_q;
    if (upper_we) begin
      for (int k = 0; k < 3; k++) begin
        win_d[k*3]   = win_q[k*3+1];
        win_d[k*3+1] = win_q[k*3+2];
      end
      win_d[2] = up_eff;
      win_d[5] = mid_rd;
      win_d[8] = s1_q.pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_N; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      win_q <= win_d;
    end
  end

  // occupied neighbours of the new centre
  always_comb begin
    nb_cnt = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (i != WIN_CENTRE && win_d[i] != '0) begin
        nb_cnt = nb_cnt + 4'd1;
      end
    end
  end

  // centre kept when empty or bridged east-west or north-south
  assign keep = (win_d[WIN_CENTRE] == '0) ||
                ((win_d[WIN_WEST] != '0) && (win_d[WIN_EAST] != '0)) ||
                ((win_d[WIN_NORTH] != '0) && (win_d[WIN_SOUTH] != '0));

  // result selection
  always_comb begin
    if (s1_q.flush) begin
      value = s1_q.sel_mid ? mid_rd : up_eff;
    end else if (s1_q.border) begin
      value = win_q[WIN_EAST];
    end else if (!s1_q.interior || keep) begin
      value = win_d[WIN_CENTRE];
    end else if (nb_cnt <= 4'(SPARSE_LIMIT)) begin
      value = sparse_code_i;
    end else begin
      value = dense_code_i;
    end
  end

  assign push_o       = s1_q.valid && s1_q.emit;
  assign item_o.pixel = value;
  assign item_o.last  = s1_q.last;

  // forwarding only ever follows a pixel write-back
  `NRPF_ASSERT(a_fwd_after_pixel, clk_i, rst_ni, fwd_hit_q |-> $past(s1_q.valid && !s1_q.flush), "upper forward without write-back")

  // every result comes from a request issued the cycle before
  `NRPF_ASSERT(a_push_from_issue, clk_i, rst_ni, push_o |-> $past(issue_i.valid && issue_i.emit), "result without issued request")

endmodule

// ===== hw/rtl/nrpf_outq.sv =====
// ---------------------------------------------------------------------------
// nrpf_outq
// small result queue between the datapath and the output channel
// ---------------------------------------------------------------------------
`include "neighbor_rule_pixel_filter_macros.svh"

module nrpf_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  nrpf_pkg::out_item_t item_i,
  input  logic                ready_i,
  output logic                valid_o,
  output nrpf_pkg::out_item_t item_o,
  output logic                space_o
);

  import nrpf_pkg::*;

  localparam int unsigned Depth = OUTQ_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  out_item_t       slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = cnt_q != '0;
  assign item_o  = slot_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  // room for one more request counting the result still in the datapath
  assign space_o = ({1'b0, cnt_q} + (CntW+1)'(push_i)) < (CntW+1)'(Depth);

  // occupancy
  always_comb begin
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  // result slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  // the request gating must keep a full queue from taking another result
  `NRPF_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && !pop && cnt_q == CntW'(Depth), "result pushed into full queue")

endmodule

// ===== hw/rtl/neighbor_rule_pixel_filter.sv =====
// ---------------------------------------------------------------------------
// neighbor_rule_pixel_filter
// raster 3x3 neighbour rule filter for a mostly binary image
// ---------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order, tuser low; tuser high
// marks a drain request. Filtered pixels leave on m_axis in raster order,
// tlast high on the final pixel of a frame. Output pixel (r,c) is produced
// when input (r+1,c+1) is taken; after the last pixel of a frame, send
// frame_width+1 drain requests to flush the last row and column.
// One request is taken per clock while the result queue has room; a request
// passes the line store read, then the window update and the write into the
// result queue, before its result is presented on m_axis. Each line store
// read is registered, and the upper store write-back is forwarded to a read
// of the same column issued in the cycle of the write. Geometry and codes
// must be written on the cfg port while the block is idle; the block does
// not enforce this. Reset returns the registers to their defaults, the
// positions to the frame origin and empties the result queue; the line
// stores are not cleared. A stalled receiver fills a three-entry result
// queue, after which s_axis_tready stays low until m_axis takes a result.
// ---------------------------------------------------------------------------
module neighbor_rule_pixel_filter #(
  parameter int unsigned MaxWidth = nrpf_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [nrpf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nrpf_pkg::CFG_W-1:0]     cfg_data_i,
  // request channel
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [nrpf_pkg::PIX_W-1:0]     s_axis_tdata,  // [7:0] pixel_in
  input  logic                           s_axis_tuser,  // [0] req_type
  // result channel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [nrpf_pkg::PIX_W-1:0]     m_axis_tdata,  // [7:0] pixel_out
  output logic                           m_axis_tlast
);

  import nrpf_pkg::*;

  localparam int unsigned ColW = $clog2(MaxWidth);

  logic            accept;
  issue_t          issue;
  logic [ColW-1:0] addr;
  logic [PIX_W-1:0] sparse_code, dense_code;
  logic            push;
  out_item_t       push_item, head_item;
  logic            space;

  // request handshake
  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;

  // positions, registers and request issue
  nrpf_ctrl #(
    .MaxWidth (MaxWidth)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .req_type_i    (req_type_e'(s_axis_tuser)),
    .pixel_i       (s_axis_tdata),
    .issue_o       (issue),
    .addr_o        (addr),
    .sparse_code_o (sparse_code),
    .dense_code_o  (dense_code)
  );

  // line stores and window
  nrpf_dpath #(
    .MaxWidth (MaxWidth)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (issue),
    .addr_i        (addr),
    .sparse_code_i (sparse_code),
    .dense_code_i  (dense_code),
    .push_o        (push),
    .item_o        (push_item)
  );

  // result queue
  nrpf_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .item_o  (head_item),
    .space_o (space)
  );

  assign m_axis_tdata = head_item.pixel;
  assign m_axis_tlast = head_item.last;

endmodule
